### rtl/core/ipcd_pkg.sv
// Shared types and constants for the sensor packet checksum decoder.
// No dependencies; every other file of the block imports this package.
package ipcd_pkg;

  // Frame lengths in bytes.
  localparam logic [4:0] HS_LEN   = 5'd7;
  localparam logic [4:0] VEC_LEN  = 5'd23;
  localparam logic [4:0] QUAT_LEN = 5'd31;

  // Command and reply bytes.
  localparam logic [7:0] CMD_VECTOR = 8'h03;
  localparam logic [7:0] CMD_QUAT   = 8'h0C;
  localparam logic [7:0] HS_KEEP    = 8'h29;

  // Data words per frame.
  localparam logic [3:0] NWORDS_VEC  = 4'd9;
  localparam logic [3:0] NWORDS_QUAT = 4'd13;

  // Register index of the mode register.
  localparam logic REG_QUAT_MODE = 1'b0;

  // Depth of the frame descriptor queue.
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    ST_SAMPLE  = 2'd0,
    ST_BAD_CMD = 2'd1,
    ST_BAD_SUM = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD,
    BK_EMIT
  } bk_state_t;

  // One finished frame, passed from the front end to the back end.
  typedef struct packed {
    status_t     status;
    logic        bank;
    logic        quat;
    logic [15:0] timer;
  } desc_t;

  // Word write into the back end's frame memory.
  typedef struct packed {
    logic        valid;
    logic [4:0]  addr;
    logic [15:0] data;
  } wr_t;

  // Bank release from the back end once a frame is fully emitted.
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  // Scale factor of a data word by its group.
  function automatic logic [3:0] scale_factor(input logic quat, input logic [3:0] ch);
    logic [3:0] f;
    if (quat) begin
      if (ch < 4'd4)       f = 4'd4;
      else if (ch < 4'd7)  f = 4'd2;
      else if (ch < 4'd10) f = 4'd7;
      else                 f = 4'd10;
    end else begin
      if (ch < 4'd3)       f = 4'd2;
      else if (ch < 4'd6)  f = 4'd7;
      else                 f = 4'd10;
    end
    return f;
  endfunction

endpackage

### rtl/core/ipcd_front.sv
// Front end: frames received bytes, writes data words to the frame memory,
// accumulates the checksum and classifies each finished frame. Uses ipcd_pkg.
module ipcd_front #(
  parameter int MAX_FRAME_BYTES = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_rx_byte,
  output logic          in_stall,
  input  logic          quat,
  output ipcd_pkg::wr_t   wr,
  output logic          push_valid,
  output ipcd_pkg::desc_t push_desc,
  input  logic          fifo_full,
  input  ipcd_pkg::rel_t  rel
);
  import ipcd_pkg::*;

  logic [4:0]  count_r, count_nxt;
  logic        hs_r, hs_nxt;
  logic [1:0]  busy_r, busy_nxt;
  logic        wbank_r, wbank_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] prev_r, prev_nxt;

  logic        accept;
  logic        in_range;
  logic        is_end;
  logic [4:0]  len;
  logic [7:0]  byte_m;
  logic [15:0] word;
  logic [15:0] sum;
  logic [7:0]  exp_cmd;
  status_t     status;

  // The front end holds off only when the bank it fills is still owned
  // by the back end, or when no queue slot is left for a finished frame.
  assign in_stall = busy_r[wbank_r] | fifo_full;
  assign accept   = in_valid & ~in_stall;

  // Framing decode.
  always_comb begin
    len      = hs_r ? HS_LEN : (quat ? QUAT_LEN : VEC_LEN);
    in_range = (count_r < len);
    is_end   = ((count_r + 5'd1) == len);
    byte_m   = (count_r < 5'(MAX_FRAME_BYTES)) ? in_rx_byte : 8'h00;
    word     = {hi_r, byte_m};
    sum      = acc_r + {8'h00, cmd_r};
    exp_cmd  = quat ? CMD_QUAT : CMD_VECTOR;
    if (cmd_r != exp_cmd)  status = ST_BAD_CMD;
    else if (sum != word)  status = ST_BAD_SUM;
    else                   status = ST_SAMPLE;
  end

  // Word writes happen on the low byte of every pair.
  always_comb begin
    wr.valid = accept & in_range & ~count_r[0] & (count_r != 5'd0);
    wr.addr  = {wbank_r, 4'(count_r[4:1] - 4'd1)};
    wr.data  = word;
  end

  // Frame descriptor at the end of a data frame.
  always_comb begin
    push_valid       = accept & in_range & is_end & ~hs_r;
    push_desc.status = status;
    push_desc.bank   = wbank_r;
    push_desc.quat   = quat;
    push_desc.timer  = prev_r;
  end

  // Next-state logic for the framing counters and accumulators.
  always_comb begin
    count_nxt = count_r;
    hs_nxt    = hs_r;
    cmd_nxt   = cmd_r;
    hi_nxt    = hi_r;
    acc_nxt   = acc_r;
    prev_nxt  = prev_r;
    wbank_nxt = wbank_r;
    busy_nxt  = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (!in_range) begin
        // Frame length shrank under the counter: drop the byte and resync.
        count_nxt = 5'd0;
      end else begin
        count_nxt = is_end ? 5'd0 : count_r + 5'd1;
        if (count_r == 5'd0) begin
          cmd_nxt = byte_m;
          acc_nxt = 16'h0000;
        end else if (count_r[0]) begin
          hi_nxt = byte_m;
        end else if (!is_end) begin
          // Every completed pair before the checksum joins the sum.
          acc_nxt  = acc_r + word;
          prev_nxt = word;
        end
        if (is_end && hs_r) begin
          hs_nxt = (cmd_r == HS_KEEP);
        end
        if (push_valid && status == ST_SAMPLE) begin
          busy_nxt[wbank_r] = 1'b1;
          wbank_nxt         = ~wbank_r;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 5'd0;
      hs_r    <= 1'b1;
      busy_r  <= 2'b00;
      wbank_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      hs_r    <= hs_nxt;
      busy_r  <= busy_nxt;
      wbank_r <= wbank_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    hi_r   <= hi_nxt;
    acc_r  <= acc_nxt;
    prev_r <= prev_nxt;
  end

endmodule

### rtl/core/ipcd_fifo.sv
// Short queue of frame descriptors between the front end and the back end.
// Uses ipcd_pkg for the descriptor type and the queue depth.
module ipcd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ipcd_pkg::desc_t push_desc,
  input  logic            pop,
  output ipcd_pkg::desc_t head,
  output logic            head_valid,
  output logic            full
);
  import ipcd_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  desc_t            slot_r [QDEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;

  assign head       = slot_r[rp_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == (PW+1)'(QDEPTH));

  // Pointer and occupancy update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop)      cnt_nxt = cnt_r + (PW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (PW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Descriptor storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_desc;
    end
  end

endmodule

### rtl/core/ipcd_back.sv
// Back end: owns the two-bank word memory, takes frame descriptors from the
// queue and emits sample or status transactions. Uses ipcd_pkg.
module ipcd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipcd_pkg::wr_t         wr,
  input  ipcd_pkg::desc_t       head,
  input  logic                  head_valid,
  output logic                  pop,
  output ipcd_pkg::rel_t        rel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [3:0]            out_channel,
  output logic signed [19:0]    out_scaled_value,
  output logic signed [15:0]    out_raw_word,
  output logic [15:0]           out_timer_ticks,
  output logic                  out_last
);
  import ipcd_pkg::*;

  bk_state_t state_r, state_nxt;

  logic [15:0]        mem [32];
  logic [15:0]        rdata_r;
  logic [4:0]         raddr;

  logic [3:0]         ch_r, ch_nxt;
  logic               bank_r;
  logic               quat_r;
  logic [3:0]         nwords_m1;
  logic signed [20:0] prod;

  logic [1:0]         status_r;
  logic [3:0]         chan_r;
  logic signed [19:0] scaled_r;
  logic signed [15:0] raw_r;
  logic [15:0]        timer_r;
  logic               last_r;

  assign nwords_m1 = quat_r ? (NWORDS_QUAT - 4'd1) : (NWORDS_VEC - 4'd1);
  assign raddr     = {bank_r, ch_r};
  assign prod      = $signed(rdata_r) * $signed({1'b0, scale_factor(quat_r, ch_r)});

  // Word memory: one write port from the front end, one registered read.
  always_ff @(posedge clk) begin
    if (wr.valid) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          ch_nxt    = 4'd0;
          state_nxt = (head.status == ST_SAMPLE) ? BK_READ : BK_EMIT;
        end
      end
      BK_READ: state_nxt = BK_LOAD;
      BK_LOAD: state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (!out_stall) begin
          if (last_r) begin
            state_nxt = BK_IDLE;
          end else begin
            ch_nxt    = ch_r + 4'd1;
            state_nxt = BK_READ;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop       = 1'b0;
    rel.valid = 1'b0;
    rel.bank  = bank_r;
    out_valid = 1'b0;
    unique case (state_r)
      BK_IDLE: pop = head_valid;
      BK_READ, BK_LOAD: ;
      BK_EMIT: begin
        out_valid = 1'b1;
        rel.valid = ~out_stall & last_r & (status_r == ST_SAMPLE);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Frame context and output register.
  always_ff @(posedge clk) begin
    ch_r <= ch_nxt;
    if (state_r == BK_IDLE && head_valid) begin
      bank_r   <= head.bank;
      quat_r   <= head.quat;
      timer_r  <= head.timer;
      status_r <= head.status;
      chan_r   <= 4'd0;
      scaled_r <= 20'sd0;
      raw_r    <= 16'sd0;
      last_r   <= 1'b1;
    end else if (state_r == BK_LOAD) begin
      chan_r   <= ch_r;
      scaled_r <= 20'(prod);
      raw_r    <= $signed(rdata_r);
      last_r   <= (ch_r == nwords_m1);
    end
  end

  assign out_status       = status_r;
  assign out_channel      = chan_r;
  assign out_scaled_value = scaled_r;
  assign out_raw_word     = raw_r;
  assign out_timer_ticks  = timer_r;
  assign out_last         = last_r;

endmodule

### rtl/core/imu_packet_checksum_decoder.sv
// Top level of the sensor packet checksum decoder: mode register, front end,
// descriptor queue and back end. Depends on ipcd_pkg, ipcd_front, ipcd_fifo, ipcd_back.
//
//   Port group  Direction  Handshake             Payload
//   in_         input      in_valid / in_stall   in_rx_byte
//   out_        output     out_valid / out_stall status, channel, scaled value,
//                                                raw word, timer ticks, last
//   config      APB write  psel/penable/pwrite   quaternion_mode at 0x0
//
// A byte is taken every cycle; the front end stalls only while the word bank
// it would fill still holds a frame that has not been fully emitted, or the
// two-entry descriptor queue is full. The back end takes a descriptor in its
// idle state, then steps through its read, load and emit states for each sample
// transaction (memory read, scaling, output), or goes straight to emit for the
// single status transaction; out_stall holds the output register in emit.
// Reset restores 7-byte reply framing and quaternion mode; no clearing pass.
module imu_packet_checksum_decoder #(
  parameter int MAX_FRAME_BYTES = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [3:0]         out_channel,
  output logic signed [19:0] out_scaled_value,
  output logic signed [15:0] out_raw_word,
  output logic [15:0]        out_timer_ticks,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ipcd_pkg::*;

  logic  quat_r, quat_nxt;
  logic  cfg_wr;
  wr_t   wr;
  logic  push_valid;
  desc_t push_desc;
  logic  fifo_full;
  rel_t  rel;
  desc_t head;
  logic  head_valid;
  logic  pop;

  // Configuration register.
  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign quat_nxt = (cfg_wr && paddr[2] == REG_QUAT_MODE) ? pwdata[0] : quat_r;
  assign prdata   = (paddr[2] == REG_QUAT_MODE) ? {31'h0, quat_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r <= 1'b1;
    end else begin
      quat_r <= quat_nxt;
    end
  end

  ipcd_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .quat       (quat_r),
    .wr         (wr),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .fifo_full  (fifo_full),
    .rel        (rel)
  );

  ipcd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_desc  (push_desc),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (fifo_full)
  );

  ipcd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr               (wr),
    .head             (head),
    .head_valid       (head_valid),
    .pop              (pop),
    .rel              (rel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_channel      (out_channel),
    .out_scaled_value (out_scaled_value),
    .out_raw_word     (out_raw_word),
    .out_timer_ticks  (out_timer_ticks),
    .out_last         (out_last)
  );

endmodule

### rtl/core/ipcd_checker.sv
// Port-level checks for the sensor packet checksum decoder, bound to the top
// level. Depends on imu_packet_checksum_decoder and ipcd_pkg.
module ipcd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_rx_byte,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic [3:0]         out_channel,
  input logic signed [19:0] out_scaled_value,
  input logic signed [15:0] out_raw_word,
  input logic [15:0]        out_timer_ticks,
  input logic               out_last,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);
  import ipcd_pkg::*;

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result transaction keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_raw_word) && $stable(out_channel)
                               && $stable(out_timer_ticks) && $stable(out_last))
    else $error("result payload changed while stalled");

  // A status transaction is the only one of its frame and carries no word.
  a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_SAMPLE |->
      out_last && out_channel == 4'd0 && out_raw_word == 16'sd0
      && out_scaled_value == 20'sd0)
    else $error("malformed status transaction");

  // The thirteenth word always closes a frame.
  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAMPLE && out_channel == 4'd12 |-> out_last)
    else $error("last word of a frame not marked");

endmodule

bind imu_packet_checksum_decoder ipcd_checker u_ipcd_checker (.*);

### test/tb_imu_packet_checksum_decoder.sv
// Self-checking testbench for the sensor packet checksum decoder: it drives received bytes,
// predicts every decoded transaction and compares the output stream with the prediction.
// Depends on ipcd_pkg and imu_packet_checksum_decoder.
module tb_imu_packet_checksum_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import ipcd_pkg::*;

  localparam int FRAME_BYTES = 31;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] QUAT_MODE_ADDR = 3'(4 * REG_QUAT_MODE);

  typedef enum {PACE_FULL, PACE_SLOW_SINK, PACE_SLOW_SOURCE} pace_t;
  typedef enum {FR_GOOD, FR_BAD_CMD, FR_BAD_SUM, FR_JUNK} frame_kind_t;

  // One decoded output transaction as the block should present it.
  typedef struct packed {
    status_t            status;
    logic [3:0]         channel;
    logic signed [19:0] scaled;
    logic signed [15:0] raw;
    logic [15:0]        timer;
    logic               last;
  } decoded_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [3:0]         out_channel;
  logic signed [19:0] out_scaled_value;
  logic signed [15:0] out_raw_word;
  logic [15:0]        out_timer_ticks;
  logic               out_last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = 3'd0;
  logic [31:0]        pwdata = 32'd0;
  logic [31:0]        prdata;
  logic               pready;

  // Byte source, decoder mirror and the queue of predicted transactions.
  logic [7:0]    rx_queue[$];
  decoded_item_t predicted[$];
  logic [7:0]    frame_buf[FRAME_BYTES];
  logic [15:0]   word_buf[13];
  int            rx_count = 0;
  logic          hs_framing = 1'b1;
  logic          quat_mode_reg = 1'b1;
  int            bytes_queued = 0;
  int            bytes_taken = 0;
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            hold_left = 0;
  bit            byte_accepted = 1'b0;
  bit            result_accepted = 1'b0;
  bit            pressure_arm = 1'b0;
  bit            pressure_done = 1'b0;
  pace_t         pace = PACE_FULL;

  imu_packet_checksum_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_channel      (out_channel),
    .out_scaled_value (out_scaled_value),
    .out_raw_word     (out_raw_word),
    .out_timer_ticks  (out_timer_ticks),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Gain that brings a data word of a given channel to units of 2^-15.
  function automatic int channel_gain(input logic quat, input int ch);
    if (quat) begin
      if (ch <= 3) return 4;
      if (ch <= 6) return 2;
      if (ch <= 9) return 7;
      return 10;
    end
    if (ch <= 2) return 2;
    if (ch <= 5) return 7;
    return 10;
  endfunction

  // Frame one accepted byte and predict the transactions a completed frame produces.
  task automatic decode_rx_byte(input logic [7:0] rx);
    int            flen;
    int            nwords;
    logic [7:0]    cmd;
    logic [15:0]   timer;
    logic [15:0]   csum;
    logic [15:0]   sum;
    logic [15:0]   word;
    decoded_item_t item;
    flen = hs_framing ? int'(HS_LEN) : (quat_mode_reg ? int'(QUAT_LEN) : int'(VEC_LEN));
    // A shorter frame length taking effect mid-frame drops this byte and restarts framing.
    if (rx_count >= flen) begin
      rx_count = 0;
      return;
    end
    frame_buf[rx_count] = rx;
    rx_count++;
    if (rx_count != flen) return;
    rx_count = 0;

    // Handshake replies produce nothing; any reply not starting 0x29 ends handshaking.
    if (hs_framing) begin
      if (frame_buf[0] != HS_KEEP) hs_framing = 1'b0;
      return;
    end

    cmd = quat_mode_reg ? CMD_QUAT : CMD_VECTOR;
    nwords = quat_mode_reg ? int'(NWORDS_QUAT) : int'(NWORDS_VEC);
    timer = {frame_buf[flen - 4], frame_buf[flen - 3]};
    csum = {frame_buf[flen - 2], frame_buf[flen - 1]};
    item = '0;
    item.timer = timer;
    item.last = 1'b1;
    if (frame_buf[0] != cmd) begin
      item.status = ST_BAD_CMD;
      predicted = {predicted, item};
      return;
    end

    // Wrapping 16-bit sum of command byte, timer and data words.
    sum = {8'h00, cmd} + timer;
    for (int i = 0; i < nwords; i++) begin
      sum = sum + {frame_buf[2 * i + 1], frame_buf[2 * i + 2]};
    end
    if (sum != csum) begin
      item.status = ST_BAD_SUM;
      predicted = {predicted, item};
      return;
    end

    for (int i = 0; i < nwords; i++) begin
      word = {frame_buf[2 * i + 1], frame_buf[2 * i + 2]};
      item.status = ST_SAMPLE;
      item.channel = 4'(i);
      item.raw = word;
      item.scaled = 20'($signed(word) * channel_gain(quat_mode_reg, i));
      item.last = (i == nwords - 1);
      predicted = {predicted, item};
    end
  endtask

  task automatic check_field(input string name, input logic [19:0] expected,
                             input logic [19:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, expected, actual);
      mismatch_count++;
    end
  endtask

  task automatic push_rx_byte(input logic [7:0] rx);
    rx_queue = {rx_queue, rx};
    bytes_queued++;
  endtask

  // Queue one frame for the current mode built from word_buf.
  task automatic queue_frame(input frame_kind_t kind, input logic [15:0] timer);
    logic [7:0]  cmd;
    logic [7:0]  head;
    logic [15:0] sum;
    int          nwords;
    int          flen;
    cmd = quat_mode_reg ? CMD_QUAT : CMD_VECTOR;
    nwords = quat_mode_reg ? int'(NWORDS_QUAT) : int'(NWORDS_VEC);
    flen = quat_mode_reg ? int'(QUAT_LEN) : int'(VEC_LEN);
    if (kind == FR_JUNK) begin
      repeat (flen) push_rx_byte(8'($urandom));
      return;
    end
    head = cmd;
    if (kind == FR_BAD_CMD) begin
      while (head == cmd) head = 8'($urandom);
    end
    sum = {8'h00, cmd} + timer;
    for (int i = 0; i < nwords; i++) sum = sum + word_buf[i];
    if (kind == FR_BAD_SUM) sum = sum + 16'($urandom_range(65535, 1));
    push_rx_byte(head);
    for (int i = 0; i < nwords; i++) begin
      push_rx_byte(word_buf[i][15:8]);
      push_rx_byte(word_buf[i][7:0]);
    end
    push_rx_byte(timer[15:8]);
    push_rx_byte(timer[7:0]);
    push_rx_byte(sum[15:8]);
    push_rx_byte(sum[7:0]);
  endtask

  // Mostly well-formed frames with random content, plus broken and junk frames.
  task automatic queue_random_frames(input int count);
    int          pick;
    frame_kind_t kind;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 13; i++) begin
        case ($urandom_range(7))
          0: word_buf[i] = 16'h8000;
          1: word_buf[i] = 16'h7FFF;
          2: word_buf[i] = 16'h0000;
          default: word_buf[i] = 16'($urandom);
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 70) kind = FR_GOOD;
      else if (pick < 80) kind = FR_BAD_CMD;
      else if (pick < 90) kind = FR_BAD_SUM;
      else kind = FR_JUNK;
      queue_frame(kind, 16'($urandom));
    end
  endtask

  // Wait until every byte is taken and every predicted transaction has been seen.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || predicted.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == QUAT_MODE_ADDR) quat_mode_reg = data[0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Byte driver: presents the next byte once the current transaction is taken.
  always @(negedge clk) begin
    if (!in_valid || byte_accepted) begin
      if (rx_queue.size() > 0 &&
          !(pace == PACE_SLOW_SINK && $urandom_range(99) < 38) &&
          !(pace == PACE_SLOW_SOURCE && $urandom_range(99) < 62)) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls by pace, and one long hold-off when armed.
  always @(negedge clk) begin
    if (pressure_arm && !pressure_done) begin
      hold_left = HOLD_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (pace)
        PACE_SLOW_SINK: out_stall <= ($urandom_range(99) < 62);
        PACE_SLOW_SOURCE: out_stall <= ($urandom_range(99) < 38);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Monitor: predicts on accepted bytes, checks accepted results, runs the watchdog.
  always @(posedge clk) begin
    byte_accepted = rst_n && in_valid && !in_stall;
    result_accepted = rst_n && out_valid && !out_stall;
    if (result_accepted) begin
      if (predicted.size() == 0) begin
        $display("%0t: unexpected result, status %0d channel %0d raw %h timer %h",
                 $time, out_status, out_channel, out_raw_word, out_timer_ticks);
        mismatch_count++;
      end else begin
        decoded_item_t exp_item;
        exp_item = predicted.pop_front();
        check_field("status", 20'(exp_item.status), 20'(out_status));
        check_field("channel", 20'(exp_item.channel), 20'(out_channel));
        check_field("scaled_value", exp_item.scaled, out_scaled_value);
        check_field("raw_word", 20'(exp_item.raw), 20'(out_raw_word));
        check_field("timer_ticks", 20'(exp_item.timer), 20'(out_timer_ticks));
        check_field("last", 20'(exp_item.last), 20'(out_last));
      end
    end
    if (byte_accepted) begin
      decode_rx_byte(in_rx_byte);
      bytes_taken++;
    end
    if (byte_accepted || result_accepted) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_imu_packet_checksum_decoder: FAIL");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    pace = PACE_SLOW_SINK;
    write_reg(QUAT_MODE_ADDR, 32'd1);

    // A reply starting 0x29 keeps handshake framing; 0x28 switches to data frames.
    push_rx_byte(HS_KEEP);
    repeat (6) push_rx_byte(8'($urandom));
    push_rx_byte(8'h28);
    repeat (6) push_rx_byte(8'($urandom));

    // Quaternion frames with extreme words in every group, then the two error cases.
    for (int i = 0; i < 13; i++) word_buf[i] = (i % 2) ? 16'h8000 : 16'h7FFF;
    queue_frame(FR_GOOD, 16'hFFFF);
    queue_frame(FR_BAD_CMD, 16'h1234);
    queue_frame(FR_BAD_SUM, 16'h0000);

    // Switch to vector mode with more bytes held than a vector frame has.
    repeat (25) push_rx_byte(8'($urandom));
    wait_drained();
    write_reg(QUAT_MODE_ADDR, 32'd0);
    push_rx_byte(8'hFF);
    for (int i = 0; i < 13; i++) word_buf[i] = (i % 2) ? 16'h7FFF : 16'h8000;
    queue_frame(FR_GOOD, 16'h8001);
    queue_frame(FR_BAD_CMD, 16'hFFFF);

    wait_drained();
    write_reg(QUAT_MODE_ADDR, 32'd1);
    pace = PACE_SLOW_SOURCE;
    queue_random_frames(1);

    // Full rate with one long receiver hold-off to back the block up.
    wait_drained();
    write_reg(QUAT_MODE_ADDR, 32'd0);
    pace = PACE_FULL;
    queue_random_frames(4);
    pressure_arm = 1'b1;

    wait_drained();
    write_reg(QUAT_MODE_ADDR, 32'd1);
    queue_random_frames(1);

    wait_drained();
    if (mismatch_count == 0 && predicted.size() == 0) begin
      $display("tb_imu_packet_checksum_decoder: PASS");
    end else begin
      $display("tb_imu_packet_checksum_decoder: FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ipcd_pkg.sv
rtl/core/ipcd_front.sv
rtl/core/ipcd_fifo.sv
rtl/core/ipcd_back.sv
rtl/core/imu_packet_checksum_decoder.sv
rtl/core/ipcd_checker.sv
test/tb_imu_packet_checksum_decoder.sv
